FILE: sv/ttdt_pkg.sv
// shared types and constants for the task tag dependency tracker
// no dependencies
package ttdt_pkg;

  localparam logic [1:0] OP_DECLARE  = 2'd0;
  localparam logic [1:0] OP_ADD_DEP  = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;
  localparam logic [1:0] OP_IGNORED  = 2'd3;

  localparam logic [1:0] ST_UNASSIGNED = 2'd0;
  localparam logic [1:0] ST_BLOCKED    = 2'd1;
  localparam logic [1:0] ST_READY      = 2'd2;
  localparam logic [1:0] ST_DONE       = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_FULL = 2'd1;
  localparam logic [1:0] ERR_ZERO = 2'd2;

  // command passed from front to back
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] tag;
    logic [7:0] dep_tag;
    logic [7:0] count;
  } cmd_t;

endpackage

FILE: sv/ttdt_front.sv
// front end: accepts transactions into a small command queue
// depends on ttdt_pkg
module ttdt_front #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ttdt_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output ttdt_pkg::cmd_t  head
);
  localparam int AW = $clog2(DEPTH);

  ttdt_pkg::cmd_t     mem [DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [AW:0]        fill;

  assign full  = (fill == (AW+1)'(DEPTH));
  assign empty = (fill == '0);
  assign head  = mem[rd_ptr];

  // op 3 carries no work and is dropped here
  logic keep;
  assign keep = push && (push_cmd.op != ttdt_pkg::OP_IGNORED);

  always_ff @(posedge clk) begin
    if (keep) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (keep) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      fill <= fill + (AW+1)'(keep) - (AW+1)'(pop);
    end
  end
endmodule

FILE: sv/ttdt_back.sv
// back end: tag tables, successor lists and the completion walk
// depends on ttdt_pkg
module ttdt_back #(
  parameter int TAG_COUNT      = 256,
  parameter int MAX_SUCCESSORS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  ttdt_pkg::cmd_t  cmd,
  output logic            cmd_pop,
  output logic            idle,
  output logic            ready_valid,
  output logic [7:0]      ready_tag,
  output logic [1:0]      error,
  output logic            last,
  output logic            strobe
);
  localparam int TW = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
  localparam int SW = (MAX_SUCCESSORS > 1) ? $clog2(MAX_SUCCESSORS) : 1;
  localparam int CW = $clog2(MAX_SUCCESSORS + 1);
  localparam int LW = TW + SW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_CHILD = 4'd4;
  localparam logic [3:0] S_WRD   = 4'd5;
  localparam logic [3:0] S_WLIST = 4'd6;
  localparam logic [3:0] S_WEXEC = 4'd7;

  // memories
  logic [1:0]    state_mem [TAG_COUNT];
  logic [CW-1:0] scnt_mem  [TAG_COUNT];
  logic [7:0]    pend_mem  [TAG_COUNT];
  logic [7:0]    list_mem  [TAG_COUNT*MAX_SUCCESSORS];

  logic [3:0]    fsm;
  ttdt_pkg::cmd_t cur;
  logic [TW:0]   clr_idx;
  logic [CW-1:0] walk_i;
  logic [CW-1:0] walk_n;

  // registered read data
  logic [1:0]    rd_state;
  logic [CW-1:0] rd_scnt;
  logic [7:0]    rd_pend;
  logic [7:0]    rd_list;
  logic [1:0]    rd_dstate;

  // held result for walk so last can be set on the final one
  logic          hold_v;
  logic [7:0]    hold_tag;

  logic [TW-1:0] t_idx, d_idx, child_idx;
  assign t_idx = cur.tag[TW-1:0];
  assign d_idx = cur.dep_tag[TW-1:0];
  assign child_idx = rd_list[TW-1:0];

  // table port signals
  logic          st_we;  logic [TW-1:0] st_wa; logic [1:0] st_wd;
  logic          pd_we;  logic [TW-1:0] pd_wa; logic [7:0] pd_wd;
  logic          sc_we;  logic [TW-1:0] sc_wa; logic [CW-1:0] sc_wd;
  logic          ls_we;  logic [LW-1:0] ls_wa; logic [7:0] ls_wd;
  logic [TW-1:0] st_ra, pd_ra, sc_ra, dst_ra;
  logic [LW-1:0] ls_ra;

  always_ff @(posedge clk) begin
    if (st_we) state_mem[st_wa] <= st_wd;
    if (pd_we) pend_mem[pd_wa]  <= pd_wd;
    if (sc_we) scnt_mem[sc_wa]  <= sc_wd;
    if (ls_we) list_mem[ls_wa]  <= ls_wd;
    rd_state  <= state_mem[st_ra];
    rd_dstate <= state_mem[dst_ra];
    rd_pend   <= pend_mem[pd_ra];
    rd_scnt   <= scnt_mem[sc_ra];
    rd_list   <= list_mem[ls_ra];
  end

  assign idle    = (fsm == S_IDLE) && !hold_v;
  assign cmd_pop = (fsm == S_IDLE) && cmd_valid;

  logic [LW-1:0] walk_addr;
  assign walk_addr = LW'(t_idx) * LW'(MAX_SUCCESSORS) + LW'(walk_i);

  // control and datapath
  always_comb begin
    st_we = 1'b0; st_wa = t_idx; st_wd = ttdt_pkg::ST_BLOCKED;
    pd_we = 1'b0; pd_wa = t_idx; pd_wd = cur.count;
    sc_we = 1'b0; sc_wa = d_idx; sc_wd = rd_scnt + 1'b1;
    ls_we = 1'b0;
    ls_wa = LW'(d_idx) * LW'(MAX_SUCCESSORS) + LW'(rd_scnt[SW-1:0]);
    ls_wd = cur.tag;
    st_ra = t_idx; pd_ra = t_idx; sc_ra = t_idx; dst_ra = d_idx;
    ls_ra = walk_addr;
    if (fsm == S_CLEAR) begin
      st_we = 1'b1; st_wa = clr_idx[TW-1:0]; st_wd = ttdt_pkg::ST_UNASSIGNED;
      sc_we = 1'b1; sc_wa = clr_idx[TW-1:0]; sc_wd = '0;
    end else if (fsm == S_RD1 && cur.op == ttdt_pkg::OP_ADD_DEP) begin
      sc_ra = d_idx;
    end else if (fsm == S_EXEC) begin
      case (cur.op)
        ttdt_pkg::OP_DECLARE: begin
          st_we = 1'b1; pd_we = 1'b1;
        end
        ttdt_pkg::OP_ADD_DEP: begin
          if (rd_dstate == ttdt_pkg::ST_DONE) begin
            if (rd_state == ttdt_pkg::ST_BLOCKED && rd_pend != 8'd0) begin
              pd_we = 1'b1; pd_wd = rd_pend - 8'd1;
              if (rd_pend == 8'd1) begin
                st_we = 1'b1; st_wd = ttdt_pkg::ST_READY;
              end
            end
          end else if (rd_scnt < CW'(MAX_SUCCESSORS)) begin
            sc_we = 1'b1; ls_we = 1'b1;
          end
        end
        default: begin
          st_we = 1'b1; st_wd = ttdt_pkg::ST_DONE;
        end
      endcase
    end else if (fsm == S_WLIST || fsm == S_WRD) begin
      // keep the child address on the table ports until its data lands
      st_ra = child_idx; pd_ra = child_idx;
    end else if (fsm == S_CHILD) begin
      st_wa = child_idx; pd_wa = child_idx;
      if (rd_state == ttdt_pkg::ST_BLOCKED && rd_pend != 8'd0) begin
        pd_we = 1'b1; pd_wd = rd_pend - 8'd1;
        if (rd_pend == 8'd1) begin
          st_we = 1'b1; st_wd = ttdt_pkg::ST_READY;
        end
      end
    end
  end

  logic child_fire;
  assign child_fire = (rd_state == ttdt_pkg::ST_BLOCKED) && (rd_pend == 8'd1);

  // a result goes out in the cycle after these conditions
  logic emit;
  always_comb begin
    emit = 1'b0;
    case (fsm)
      S_EXEC: begin
        if (cur.op == ttdt_pkg::OP_DECLARE) begin
          emit = (cur.count == 8'd0);
        end else if (cur.op == ttdt_pkg::OP_ADD_DEP) begin
          if (rd_dstate == ttdt_pkg::ST_DONE) emit = child_fire;
          else emit = (rd_scnt >= CW'(MAX_SUCCESSORS));
        end
      end
      S_WEXEC: emit = (walk_i == walk_n) && hold_v;
      S_CHILD: emit = child_fire && hold_v;
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else strobe <= emit;
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cur <= cmd;
    if (rst) begin
      fsm <= S_CLEAR; clr_idx <= '0; hold_v <= 1'b0;
      walk_i <= '0; walk_n <= '0;
    end else begin
      case (fsm)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (TW+1)'(TAG_COUNT-1)) fsm <= S_IDLE;
        end
        S_IDLE: if (cmd_pop) fsm <= S_RD1;
        S_RD1: fsm <= S_EXEC;
        S_EXEC: begin
          fsm <= S_IDLE;
          case (cur.op)
            ttdt_pkg::OP_DECLARE: begin
              if (cur.count == 8'd0) begin
                ready_valid <= 1'b0; ready_tag <= 8'd0;
                error <= ttdt_pkg::ERR_ZERO; last <= 1'b1;
              end
            end
            ttdt_pkg::OP_ADD_DEP: begin
              if (rd_dstate == ttdt_pkg::ST_DONE) begin
                if (rd_state == ttdt_pkg::ST_BLOCKED && rd_pend == 8'd1) begin
                  ready_valid <= 1'b1; ready_tag <= cur.tag;
                  error <= ttdt_pkg::ERR_NONE; last <= 1'b1;
                end
              end else if (rd_scnt >= CW'(MAX_SUCCESSORS)) begin
                ready_valid <= 1'b0; ready_tag <= 8'd0;
                error <= ttdt_pkg::ERR_FULL; last <= 1'b1;
              end
            end
            default: begin
              walk_i <= '0;
              walk_n <= rd_scnt;
              hold_v <= 1'b0;
              fsm <= S_WEXEC;
            end
          endcase
        end
        S_WEXEC: begin
          // list read issued at walk_addr this cycle
          if (walk_i == walk_n) begin
            if (hold_v) begin
              ready_valid <= 1'b1; ready_tag <= hold_tag;
              error <= ttdt_pkg::ERR_NONE; last <= 1'b1;
            end
            hold_v <= 1'b0;
            fsm <= S_IDLE;
          end else begin
            fsm <= S_WLIST;
          end
        end
        S_WLIST: fsm <= S_WRD;
        S_WRD: fsm <= S_CHILD;
        S_CHILD: begin
          if (child_fire) begin
            if (hold_v) begin
              ready_valid <= 1'b1; ready_tag <= hold_tag;
              error <= ttdt_pkg::ERR_NONE; last <= 1'b0;
            end
            hold_v <= 1'b1;
            hold_tag <= rd_list;
          end
          walk_i <= walk_i + 1'b1;
          fsm <= S_WEXEC;
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/task_tag_dependency_tracker.sv
// top level of the task tag dependency tracker
// depends on ttdt_pkg, ttdt_front, ttdt_back
// After reset the back end clears its tag tables, one tag at a time;
// the command queue still takes up to two transactions in that time and
// busy rises once it is full. A declaration or add-dependency transaction
// reads its tag tables and then updates them in the back end; a completion
// walks the tag's successor list (at most MAX_SUCCESSORS entries) with a
// read-modify-write of each child's pending count through one table
// port. Each result is marked by a pulse on strobe and cannot be held off;
// a two-entry command queue lets start be taken while the back end works.
module task_tag_dependency_tracker #(
  parameter int TAG_COUNT      = 256,
  parameter int MAX_SUCCESSORS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op,
  input  logic [7:0] tag,
  input  logic [7:0] dep_tag,
  input  logic [7:0] count,
  output logic       strobe,
  output logic       ready_valid,
  output logic [7:0] ready_tag,
  output logic [1:0] error,
  output logic       last
);
  ttdt_pkg::cmd_t in_cmd, head;
  logic full, empty, pop, idle;

  assign in_cmd = '{op: op, tag: tag, dep_tag: dep_tag, count: count};
  assign busy = full;

  ttdt_front #(.DEPTH(2)) u_front (
    .clk(clk), .rst(rst), .push(start && !busy), .push_cmd(in_cmd),
    .full(full), .pop(pop), .empty(empty), .head(head)
  );

  ttdt_back #(.TAG_COUNT(TAG_COUNT), .MAX_SUCCESSORS(MAX_SUCCESSORS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(!empty), .cmd(head), .cmd_pop(pop),
    .idle(idle), .ready_valid(ready_valid), .ready_tag(ready_tag),
    .error(error), .last(last), .strobe(strobe)
  );

  // a result flagged ready always carries no error
  assert property (@(posedge clk) disable iff (rst)
    strobe && ready_valid |-> error == ttdt_pkg::ERR_NONE)
    else $error("ready result with error");

  // error results are always final
  assert property (@(posedge clk) disable iff (rst)
    strobe && error != ttdt_pkg::ERR_NONE |-> last)
    else $error("error result not last");

  // back end takes no command while it is not idle
  assert property (@(posedge clk) disable iff (rst)
    pop |-> idle && !empty)
    else $error("pop while back end busy or queue empty");
endmodule

FILE: verif/tb_top.sv
// self-checking testbench for task_tag_dependency_tracker
// depends on ttdt_pkg and the tracker rtl; a scoreboard class predicts ready tags
module tb_top;

  localparam int TAGS      = 256;
  localparam int MAX_SUCC  = 16;
  localparam int NUM_ITEMS = 430;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic       rdy;
    logic [7:0] rtag;
    logic [1:0] err;
    logic       lst;
  } ready_event_t;

  // tracks tag tables and the ready events still owed by the block
  class ready_scoreboard;
    logic [1:0] state_tbl [TAGS];
    logic [4:0] succ_used [TAGS];
    logic [7:0] succ_tbl  [TAGS][MAX_SUCC];
    logic [7:0] pend_tbl  [TAGS];
    ready_event_t owed [$];
    int fails;

    function new();
      for (int i = 0; i < TAGS; i++) begin
        state_tbl[i] = ttdt_pkg::ST_UNASSIGNED;
        succ_used[i] = '0;
        pend_tbl[i]  = '0;
      end
      fails = 0;
    endfunction

    // decrement one child, report whether it just became ready
    function bit release_child(logic [7:0] child);
      if (state_tbl[child] != ttdt_pkg::ST_BLOCKED || pend_tbl[child] == 0) return 0;
      pend_tbl[child] = pend_tbl[child] - 8'd1;
      if (pend_tbl[child] == 0) begin
        state_tbl[child] = ttdt_pkg::ST_READY;
        return 1;
      end
      return 0;
    endfunction

    function void owe(logic r, logic [7:0] t, logic [1:0] e);
      ready_event_t ev;
      ev.rdy = r;
      ev.rtag = t;
      ev.err = e;
      ev.lst = 1'b0;
      owed.push_back(ev);
    endfunction

    // apply an accepted transaction and queue the events it causes
    function void note_transaction(logic [1:0] o, logic [7:0] t, logic [7:0] d,
                                   logic [7:0] c);
      int before_n;
      before_n = owed.size();
      case (o)
        ttdt_pkg::OP_DECLARE: begin
          state_tbl[t] = ttdt_pkg::ST_BLOCKED;
          pend_tbl[t] = c;
          if (c == 0) owe(1'b0, 8'd0, ttdt_pkg::ERR_ZERO);
        end
        ttdt_pkg::OP_ADD_DEP: begin
          if (state_tbl[d] == ttdt_pkg::ST_DONE) begin
            if (release_child(t)) owe(1'b1, t, ttdt_pkg::ERR_NONE);
          end else if (succ_used[d] < MAX_SUCC) begin
            succ_tbl[d][succ_used[d]] = t;
            succ_used[d] = succ_used[d] + 5'd1;
          end else begin
            owe(1'b0, 8'd0, ttdt_pkg::ERR_FULL);
          end
        end
        ttdt_pkg::OP_COMPLETE: begin
          state_tbl[t] = ttdt_pkg::ST_DONE;
          for (int i = 0; i < succ_used[t]; i++)
            if (release_child(succ_tbl[t][i]))
              owe(1'b1, succ_tbl[t][i], ttdt_pkg::ERR_NONE);
        end
        default: ;
      endcase
      if (owed.size() > before_n) owed[owed.size() - 1].lst = 1'b1;
    endfunction

    function void mismatch(string what);
      fails++;
      if (fails <= 10) $display("mismatch: %s", what);
    endfunction

    // compare one strobed result with the oldest owed event
    function void check_result(logic r, logic [7:0] t, logic [1:0] e, logic l);
      ready_event_t ev;
      if (owed.size() == 0) begin
        mismatch($sformatf("unexpected result valid=%0d tag=%0d err=%0d last=%0d",
                           r, t, e, l));
        return;
      end
      ev = owed.pop_front();
      if (r !== ev.rdy)
        mismatch($sformatf("ready_valid exp %0d got %0d", ev.rdy, r));
      if (t !== ev.rtag)
        mismatch($sformatf("ready_tag exp %0d got %0d", ev.rtag, t));
      if (e !== ev.err)
        mismatch($sformatf("error exp %0d got %0d", ev.err, e));
      if (l !== ev.lst)
        mismatch($sformatf("last exp %0d got %0d", ev.lst, l));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] op = ttdt_pkg::OP_DECLARE;
  logic [7:0] tag = '0;
  logic [7:0] dep_tag = '0;
  logic [7:0] count = '0;
  logic       strobe;
  logic       ready_valid;
  logic [7:0] ready_tag;
  logic [1:0] error;
  logic       last;

  ready_scoreboard sb = new();
  int sent = 0;
  int cycles = 0;
  logic [7:0] pool [32];

  task_tag_dependency_tracker dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .tag(tag), .dep_tag(dep_tag), .count(count),
    .strobe(strobe), .ready_valid(ready_valid), .ready_tag(ready_tag),
    .error(error), .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(ready_valid, ready_tag, error, last);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // hold one transaction until the block takes it
  task automatic send(logic [1:0] o, logic [7:0] t, logic [7:0] d, logic [7:0] c);
    start = 1'b1;
    op = o;
    tag = t;
    dep_tag = d;
    count = c;
    // busy is stable between the falling edge and the accepting edge
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_transaction(o, t, d, c);
    sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  // idle gap, mostly none, sometimes long
  task automatic idle_gap();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    n = 0;
    if (pick >= 95) n = $urandom_range(10, 40);
    else if (pick >= 75) n = $urandom_range(1, 3);
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.owed.size() != 0) @(negedge clk);
  endtask

  // declare a child, hang it on a few deps, then complete a random subset of those deps
  task automatic dependency_group();
    logic [7:0] child;
    logic [7:0] deps [4];
    int n;
    child = pool[$urandom_range(0, 31)];
    n = $urandom_range(1, 4);
    send(ttdt_pkg::OP_DECLARE, child, 8'($urandom), 8'(n));
    idle_gap();
    for (int i = 0; i < n; i++) begin
      deps[i] = pool[$urandom_range(0, 31)];
      send(ttdt_pkg::OP_ADD_DEP, child, deps[i], 8'($urandom));
      idle_gap();
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        send(ttdt_pkg::OP_COMPLETE, deps[i], 8'($urandom), 8'($urandom));
        idle_gap();
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) pool[i] = 8'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero count, extremes, done deps, full list, unused op
    send(ttdt_pkg::OP_DECLARE, 8'd0, 8'd0, 8'd0);
    send(ttdt_pkg::OP_DECLARE, 8'd255, 8'd255, 8'd255);
    send(ttdt_pkg::OP_ADD_DEP, 8'd255, 8'd255, 8'd0);
    send(ttdt_pkg::OP_DECLARE, 8'd1, 8'd0, 8'd2);
    send(ttdt_pkg::OP_ADD_DEP, 8'd1, 8'd5, 8'd0);
    send(ttdt_pkg::OP_ADD_DEP, 8'd1, 8'd6, 8'd0);
    send(ttdt_pkg::OP_COMPLETE, 8'd5, 8'd0, 8'd0);
    send(ttdt_pkg::OP_COMPLETE, 8'd6, 8'd0, 8'd0);
    send(ttdt_pkg::OP_COMPLETE, 8'd6, 8'd0, 8'd0);
    send(ttdt_pkg::OP_ADD_DEP, 8'd1, 8'd6, 8'd0);
    send(ttdt_pkg::OP_DECLARE, 8'd2, 8'd0, 8'd1);
    send(ttdt_pkg::OP_ADD_DEP, 8'd2, 8'd6, 8'd0);
    send(ttdt_pkg::OP_IGNORED, 8'd255, 8'd255, 8'd255);
    send(ttdt_pkg::OP_DECLARE, 8'd3, 8'd0, 8'd16);
    for (int i = 0; i < 17; i++) send(ttdt_pkg::OP_ADD_DEP, 8'd3, 8'd200, 8'd0);
    send(ttdt_pkg::OP_COMPLETE, 8'd200, 8'd0, 8'd0);
    send(ttdt_pkg::OP_DECLARE, 8'd6, 8'd0, 8'd1);
    send(ttdt_pkg::OP_COMPLETE, 8'd255, 8'd0, 8'd0);
    wait_drained();

    // random: mostly dependency groups, some raw noise
    while (sent < NUM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        dependency_group();
      end else begin
        send(2'($urandom), ($urandom_range(0, 1) != 0) ? pool[$urandom_range(0, 31)]
                                                       : 8'($urandom),
             pool[$urandom_range(0, 31)], 8'($urandom));
        idle_gap();
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
